// File: sv/boc_pkg.sv
// ----------------------------------------------------------------------------
// boc_pkg
// shared constants and types for the box occupancy counter
// ----------------------------------------------------------------------------
`default_nettype none

package boc_pkg;

    localparam int MAX_BOXES = 64;
    localparam int MAX_DIMS  = 4;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 16;
    localparam int DIMS_W    = 3;
    localparam int COUNT_W   = 24;
    localparam int IDX_W     = 6;
    localparam int USED_W    = 7;
    localparam int BOX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int DIFF_W    = COORD_W + 1;
    localparam int TWICE_W   = COORD_W + 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [DIMS_W-1:0]  DIMS_CAP  = DIMS_W'(MAX_DIMS);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(4);

    localparam logic CFG_BOX_SIZE = 1'b0;
    localparam logic CFG_DIMS     = 1'b1;

    typedef logic [MAX_DIMS-1:0][COORD_W-1:0] t_point;

    typedef struct packed {
        logic in_use;
        logic cmp_en;
        logic fire;
        logic create;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/boc_cell.sv
// ----------------------------------------------------------------------------
// boc_cell
// one box slot: holds a centre and count, tests a point, joins the
// first-match chain and applies the increment or the new-box write
// ----------------------------------------------------------------------------
`default_nettype none

module boc_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire boc_pkg::t_cell_ctl      i_ctl,
    input  wire boc_pkg::t_point         i_point,
    input  wire [boc_pkg::SIZE_W-1:0]    i_box_size,
    input  wire [boc_pkg::DIMS_W-1:0]    i_dims,
    input  wire                          i_take,
    output logic                         o_take,
    output logic                         o_grant,
    output logic [boc_pkg::COUNT_W-1:0]  o_total
);
    import boc_pkg::*;

    t_point               r_centre;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_match;
    logic                 n_match;
    logic [COUNT_W-1:0]   w_inc;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        logic [TWICE_W-1:0]       twice;
        n_match = i_ctl.in_use;
        for (int d = 0; d < MAX_DIMS; d++) begin
            diff  = DIFF_W'($signed(i_point[d])) - DIFF_W'($signed(r_centre[d]));
            mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            twice = {mag, 1'b0};
            if ((DIMS_W'(d) < i_dims) && (twice > TWICE_W'(i_box_size))) begin
                n_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_match <= n_match;
        end
    end

    assign w_inc   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
    assign o_take  = i_take | r_match;
    assign o_grant = r_match & ~i_take;
    assign o_total = o_grant ? w_inc : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && o_grant) begin
            r_count <= w_inc;
        end else if (i_ctl.create) begin
            r_count  <= COUNT_W'(1);
            r_centre <= i_point;
        end
    end

endmodule

`default_nettype wire

// File: sv/box_occupancy_counter_core.sv
// ----------------------------------------------------------------------------
// box_occupancy_counter_core
// leader-style box counting over a row of box cells with first-match chain
// ----------------------------------------------------------------------------
// on accept the point is compared in all cells and each match is registered;
//   the update step then runs the first-match chain, updates the picked cell
//   and writes the result to the output register
// a new item is not taken until the current one has been through its update
// a full output register stalls the update step and holds off the next item
// reset: synchronous active low; box table empty, box_size 256, dims_in_use 4
// ----------------------------------------------------------------------------
`default_nettype none

module box_occupancy_counter_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_index,
    input  wire [boc_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [63:0]                   s_axis_tdata,  // coord_0, coord_1, coord_2, coord_3
    input  wire                          s_axis_tuser,  // restart
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [39:0]                  m_axis_tdata,  // box_index, box_total, boxes_used
    output logic [1:0]                   m_axis_tuser   // new_box, overflow
);
    import boc_pkg::*;

    logic [SIZE_W-1:0]  r_box_size;
    logic [DIMS_W-1:0]  r_dims;
    logic [DIMS_W-1:0]  w_dims;

    logic               r_busy;
    t_point             r_point;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_used_eff;
    logic [CNT_W-1:0]   w_used_in;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_idx;
    logic [COUNT_W-1:0] r_total;
    logic [USED_W-1:0]  r_boxes;
    logic               r_new;
    logic               r_over;

    logic               w_accept;
    logic               w_fire;
    logic               w_hit;
    logic               w_new;
    logic [MAX_BOXES:0]     w_take;
    logic [MAX_BOXES-1:0]   w_grant;
    logic [COUNT_W-1:0]     w_total_v [MAX_BOXES];
    logic [BOX_W-1:0]       w_hit_idx;
    logic [COUNT_W-1:0]     w_hit_total;
    t_point                 w_point;
    t_point                 w_cell_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_size <= SIZE_RESET;
            r_dims     <= DIMS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BOX_SIZE: r_box_size <= i_cfg_wdata;
                CFG_DIMS:     r_dims     <= i_cfg_wdata[DIMS_W-1:0];
                default:      r_dims     <= r_dims;
            endcase
        end
    end

    assign w_dims = (r_dims > DIMS_CAP) ? DIMS_CAP : r_dims;

    assign s_axis_tready = ~r_busy;
    assign w_accept      = s_axis_tvalid & ~r_busy;
    assign w_fire        = r_busy & (~r_out_valid | m_axis_tready);
    assign w_used_in     = s_axis_tuser ? '0 : r_used;

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_point[d] = s_axis_tdata[d*COORD_W +: COORD_W];
        end
    end

    assign w_cell_point = r_busy ? r_point : w_point;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_point    <= w_point;
            r_used_eff <= w_used_in;
        end
    end

    assign w_take[0] = 1'b0;

    generate
        for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
            t_cell_ctl w_ctl;
            assign w_ctl.in_use = (CNT_W'(i) < w_used_in);
            assign w_ctl.cmp_en = w_accept;
            assign w_ctl.fire   = w_fire;
            assign w_ctl.create = w_fire & w_new & (CNT_W'(i) == r_used_eff);

            boc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_point    (w_cell_point),
                .i_box_size (r_box_size),
                .i_dims     (w_dims),
                .i_take     (w_take[i]),
                .o_take     (w_take[i+1]),
                .o_grant    (w_grant[i]),
                .o_total    (w_total_v[i])
            );
        end
    endgenerate

    assign w_hit = w_take[MAX_BOXES];
    assign w_new = ~w_hit & (r_used_eff < CNT_W'(MAX_BOXES));

    always_comb begin
        w_hit_idx   = '0;
        w_hit_total = '0;
        for (int i = 0; i < MAX_BOXES; i++) begin
            w_hit_idx   = w_hit_idx | (w_grant[i] ? BOX_W'(i) : '0);
            w_hit_total = w_hit_total | w_total_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end
            if (w_fire) begin
                r_used      <= w_new ? r_used_eff + CNT_W'(1) : r_used_eff;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_new   <= w_new;
            r_over  <= ~w_hit & ~w_new;
            r_boxes <= w_new ? USED_W'(r_used_eff + CNT_W'(1)) : USED_W'(r_used_eff);
            if (w_hit) begin
                r_idx   <= IDX_W'(w_hit_idx);
                r_total <= w_hit_total;
            end else if (w_new) begin
                r_idx   <= IDX_W'(r_used_eff);
                r_total <= COUNT_W'(1);
            end else begin
                r_idx   <= '0;
                r_total <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_boxes, r_total, r_idx};
    assign m_axis_tuser  = {r_over, r_new};

endmodule

`default_nettype wire
